### sv/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared types and constants of the row correlation FIR unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rcf_pkg;

    // Field widths
    localparam int VALUE_W     = 16;   // Q1.15 sample / coefficient
    localparam int PROD_W      = 32;   // Q2.30 product
    localparam int SUM_W       = 40;   // Q10.30 result
    localparam int ACC_W       = 42;   // exact sum, covers up to 256 taps plus prior
    localparam int TAP_COUNT_W = 7;
    localparam int COEF_IDX_W  = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;

    // Command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATE = 1'b1;

    // Saturation bounds in accumulator width
    localparam logic signed [ACC_W-1:0] SUM_MAX =
        {{(ACC_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SUM_MIN = ~SUM_MAX;

    // Controls from the sequencer to the MAC
    typedef struct packed {
        logic start;    // load accumulator with the initial sum
        logic issue;    // one tap step enters the MAC pipe
        logic tap_ok;   // this step lies inside the active window
        logic coef_wr;  // coefficient write
    } rcf_mac_ctl_t;

endpackage

`default_nettype wire

### sv/rcf_tap_cell.sv
// ----------------------------------------------------------------------------
// rcf_tap_cell
// One cell of the sample chain: holds one window sample, takes its
// neighbor's sample whenever the chain moves.
// ----------------------------------------------------------------------------
`default_nettype none

module rcf_tap_cell (
    input  wire logic                                 aclk,
    input  wire logic                                 shift_en,
    input  wire logic signed [rcf_pkg::VALUE_W-1:0]   d,
    output logic signed [rcf_pkg::VALUE_W-1:0]        q
);
    import rcf_pkg::*;

    logic signed [VALUE_W-1:0] sample_reg;

    // sample storage, no reset needed: only samples of the current row are read
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            sample_reg <= d;
        end
    end

    assign q = sample_reg;

endmodule

`default_nettype wire

### sv/rcf_mac.sv
// ----------------------------------------------------------------------------
// rcf_mac
// Coefficient memory and one multiply-accumulate unit fed by the head of
// the sample chain, with saturation of the final sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rcf_mac #(
    parameter int MAX_TAPS = 64,
    parameter int AW       = 6
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire rcf_pkg::rcf_mac_ctl_t                ctl,
    input  wire logic [AW-1:0]                        rd_addr,
    input  wire logic [AW-1:0]                        wr_addr,
    input  wire logic signed [rcf_pkg::VALUE_W-1:0]   wr_data,
    input  wire logic signed [rcf_pkg::VALUE_W-1:0]   head_sample,
    input  wire logic signed [rcf_pkg::SUM_W-1:0]     init_sum,
    output logic                                      busy,
    output logic signed [rcf_pkg::SUM_W-1:0]          sat_sum
);
    import rcf_pkg::*;

    logic signed [VALUE_W-1:0] coef_mem [MAX_TAPS];

    logic                      a_vld_reg;
    logic                      a_ok_reg;
    logic signed [VALUE_W-1:0] a_samp_reg;
    logic signed [VALUE_W-1:0] a_coef_reg;
    logic                      b_vld_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    // coefficient memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ctl.coef_wr) begin
            coef_mem[wr_addr] <= wr_data;
        end
        a_coef_reg <= coef_mem[rd_addr];
    end

    // pipe valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= ctl.issue;
            b_vld_reg <= a_vld_reg;
        end
    end

    // operand stage, product stage, accumulator
    always_ff @(posedge aclk) begin
        a_samp_reg <= head_sample;
        a_ok_reg   <= ctl.tap_ok;
        prod_reg   <= a_ok_reg ? PROD_W'(a_samp_reg * a_coef_reg) : '0;
        if (ctl.start) begin
            acc_reg <= ACC_W'(init_sum);
        end else if (b_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign busy = a_vld_reg || b_vld_reg;

    // clamp to the Q10.30 range
    always_comb begin
        if (acc_reg > SUM_MAX) begin
            sat_sum = SUM_MAX[SUM_W-1:0];
        end else if (acc_reg < SUM_MIN) begin
            sat_sum = SUM_MIN[SUM_W-1:0];
        end else begin
            sat_sum = acc_reg[SUM_W-1:0];
        end
    end

`ifndef SYNTHESIS
    // the accumulator is never reloaded while products are still in flight
    ast_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.start |-> !busy)
        else $error("rcf_mac: start while pipe busy");
    // an issued step passes through the operand and product stages to the accumulator
    ast_pipe_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.issue |=> ##1 b_vld_reg)
        else $error("rcf_mac: step lost in pipe");
    // no coefficient write during a tap pass
    ast_wr_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.issue |-> !ctl.coef_wr)
        else $error("rcf_mac: coefficient write during pass");
`endif

endmodule

`default_nettype wire

### sv/row_correlation_fir_unit.sv
// ----------------------------------------------------------------------------
// row_correlation_fir_unit
// Streaming row-wise correlation FIR: a chain of sample cells that rotates
// past one shared multiply-accumulate unit.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_wr_en             cfg_index, cfg_data
//   s_       in         s_valid / s_ready     command, coef_index, value,
//                                             prior_sum, first/last_in_row
//   m_       out        m_valid / m_ready     sum, row_done
//
// A coefficient load or a sample that completes no window leaves the unit
// idle and ready for the next item. A sample that completes a window starts
// a pass: the chain rotates once through all MAX_TAPS cells past the single
// MAC, then the two-stage MAC pipe drains. Synchronous active-low reset
// clears control, fill count and registers; no clearing pass. A result
// waits in the output register while the next item is taken; the pass
// only stalls at its end when that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module row_correlation_fir_unit #(
    parameter int MAX_TAPS = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration
    input  wire logic                                   cfg_wr_en,
    input  wire logic [rcf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [rcf_pkg::CFG_DATA_W-1:0]         cfg_data,
    // input items
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_command,
    input  wire logic [rcf_pkg::COEF_IDX_W-1:0]         s_coef_index,
    input  wire logic signed [rcf_pkg::VALUE_W-1:0]     s_value,
    input  wire logic signed [rcf_pkg::SUM_W-1:0]       s_prior_sum,
    input  wire logic                                   s_first_in_row,
    input  wire logic                                   s_last_in_row,
    // result items
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [rcf_pkg::SUM_W-1:0]            m_sum,
    output logic                                        m_row_done
);
    import rcf_pkg::*;

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int FW = $clog2(MAX_TAPS + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic [AW-1:0]              step_reg;
    logic [FW-1:0]              fill_reg, fill_next;
    logic [TAP_COUNT_W-1:0]     tap_count_reg;
    logic                       accumulate_reg;
    logic                       last_reg;
    logic                       m_valid_reg;
    logic signed [SUM_W-1:0]    m_sum_reg;
    logic                       m_row_done_reg;

    logic                       s_accept, smp_accept, ld_accept;
    logic [FW-1:0]              taps;
    logic                       emit, finish, out_free, shift_en, last_step;
    logic [FW:0]                pos_sum;
    logic signed [VALUE_W-1:0]  feed;
    logic signed [VALUE_W-1:0]  cell_q [MAX_TAPS];
    rcf_mac_ctl_t               mac_ctl;
    logic                       mac_busy;
    logic signed [SUM_W-1:0]    mac_sum;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg  <= TAP_COUNT_W'(1);
            accumulate_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TAP_COUNT:  tap_count_reg  <= cfg_data[TAP_COUNT_W-1:0];
                CFG_ACCUMULATE: accumulate_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake
    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign smp_accept = s_accept && (s_command == CMD_SAMPLE);
    assign ld_accept  = s_accept && (s_command == CMD_LOAD);

    // window length in use, clamped to 1..MAX_TAPS
    always_comb begin
        if (tap_count_reg == '0) begin
            taps = FW'(1);
        end else if (32'(tap_count_reg) > MAX_TAPS) begin
            taps = FW'(MAX_TAPS);
        end else begin
            taps = FW'(tap_count_reg);
        end
    end

    // row fill, saturating at MAX_TAPS
    always_comb begin
        fill_next = s_first_in_row ? '0 : fill_reg;
        if (32'(fill_next) < MAX_TAPS) begin
            fill_next = fill_next + FW'(1);
        end
    end

    assign emit = (fill_next >= taps);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (smp_accept) begin
            fill_reg <= fill_next;
        end
    end

    // sample chain: shifts in a new sample, rotates during a pass
    assign shift_en = smp_accept || (state_reg == ST_RUN);
    assign feed     = (state_reg == ST_RUN) ? cell_q[0] : s_value;

    for (genvar q = 0; q < MAX_TAPS; q++) begin : g_cell
        if (q == MAX_TAPS - 1) begin : g_tail
            rcf_tap_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d        (feed),
                .q        (cell_q[q])
            );
        end else begin : g_body
            rcf_tap_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d        (cell_q[q+1]),
                .q        (cell_q[q])
            );
        end
    end

    // tap position: step p maps to coefficient p - (MAX_TAPS - taps)
    assign pos_sum   = (FW+1)'(step_reg) + (FW+1)'(taps);
    assign last_step = (step_reg == AW'(MAX_TAPS - 1));
    assign out_free  = !m_valid_reg || m_ready;
    assign finish    = (state_reg == ST_DRAIN) && !mac_busy && out_free;

    always_comb begin
        mac_ctl.start   = smp_accept && emit;
        mac_ctl.issue   = (state_reg == ST_RUN);
        mac_ctl.tap_ok  = (32'(pos_sum) >= MAX_TAPS);
        mac_ctl.coef_wr = ld_accept && (32'(s_coef_index) < MAX_TAPS);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (smp_accept && emit) state_next = ST_RUN;
            ST_RUN:   if (last_step)          state_next = ST_DRAIN;
            ST_DRAIN: if (finish)             state_next = ST_IDLE;
            default:                          state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_RUN) begin
                step_reg <= last_step ? '0 : step_reg + AW'(1);
            end else begin
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (smp_accept) begin
            last_reg <= s_last_in_row;
        end
    end

    rcf_mac #(
        .MAX_TAPS (MAX_TAPS),
        .AW       (AW)
    ) u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (mac_ctl),
        .rd_addr     (AW'(pos_sum - (FW+1)'(MAX_TAPS))),
        .wr_addr     (AW'(s_coef_index)),
        .wr_data     (s_value),
        .head_sample (cell_q[0]),
        .init_sum    (accumulate_reg ? s_prior_sum : '0),
        .busy        (mac_busy),
        .sat_sum     (mac_sum)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_sum_reg      <= mac_sum;
            m_row_done_reg <= last_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_sum      = m_sum_reg;
    assign m_row_done = m_row_done_reg;

`ifndef SYNTHESIS
    // the MAC pipe is empty whenever a new item can be taken
    ast_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mac_busy)
        else $error("row_correlation_fir_unit: MAC busy while idle");
    // a completed window starts a pass at the first tap step
    ast_pass_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (smp_accept && emit) |=> (state_reg == ST_RUN) && (step_reg == '0))
        else $error("row_correlation_fir_unit: pass did not start");
    // a result appears only at the end of a pass
    ast_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DRAIN))
        else $error("row_correlation_fir_unit: result without pass");
    // the state register stays one-hot
    ast_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("row_correlation_fir_unit: state not one-hot");
`endif

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for row_correlation_fir_unit. Coefficient loads and
// row-structured sample streams go in over the s_ channel, and the window
// sums are predicted from a local copy of the tap table and the sample
// window. Each result leaving on the m_ channel is compared in order.
// Both channels idle at random. Phases sweep tap_count (including 0 and
// values above the table size) and accumulate mode.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import rcf_pkg::*;

    localparam int TAP_SLOTS = 64;
    localparam int DRAIN_CYCLES = TAP_SLOTS + 12;
    localparam int RUN_LIMIT = 2_000_000;
    localparam int PHASE_ITEMS = 150;

    // One input item and one result item
    typedef struct {
        logic                        command;
        logic [COEF_IDX_W-1:0]       coef_index;
        logic signed [VALUE_W-1:0]   value;
        logic signed [SUM_W-1:0]     prior_sum;
        logic                        first_in_row;
        logic                        last_in_row;
    } fir_item_t;

    typedef struct {
        logic signed [SUM_W-1:0] sum;
        logic                    row_done;
    } fir_sum_t;

    // Mirror of the filter state; queues the window sums it predicts
    class correlation_tracker;
        logic signed [VALUE_W-1:0] coef_table [TAP_SLOTS];
        logic signed [VALUE_W-1:0] window [TAP_SLOTS];
        int                        window_fill;
        logic [TAP_COUNT_W-1:0]    tap_count;
        logic                      accumulate;
        fir_sum_t                  expected_sums [$];
        int                        failures;

        function new();
            foreach (coef_table[i]) coef_table[i] = '0;
            foreach (window[i]) window[i] = '0;
            window_fill = 0;
            tap_count = 1;
            accumulate = 1'b0;
            failures = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_TAP_COUNT)
                tap_count = data[TAP_COUNT_W-1:0];
            else if (idx == CFG_ACCUMULATE)
                accumulate = data[0];
        endfunction

        // zero means one tap, anything past the table means the whole table
        function int taps_in_use();
            if (tap_count == 0)
                return 1;
            if (tap_count > TAP_SLOTS)
                return TAP_SLOTS;
            return int'(tap_count);
        endfunction

        // Exact correlation of the newest taps plus optional prior, clamped to 40 bits
        function logic signed [SUM_W-1:0] window_sum(logic signed [SUM_W-1:0] prior);
            longint acc;
            longint hi;
            int     taps;
            int     base;
            hi = (longint'(1) <<< (SUM_W - 1)) - 1;
            taps = taps_in_use();
            base = TAP_SLOTS - taps;
            acc = accumulate ? longint'(prior) : 0;
            for (int q = 0; q < taps; q++)
                acc += longint'(window[base + q]) * longint'(coef_table[q]);
            if (acc > hi)
                acc = hi;
            if (acc < -hi - 1)
                acc = -hi - 1;
            return acc[SUM_W-1:0];
        endfunction

        function void take_item(fir_item_t it);
            fir_sum_t want;
            if (it.command == CMD_LOAD) begin
                coef_table[it.coef_index] = it.value;
                return;
            end
            if (it.first_in_row)
                window_fill = 0;
            for (int q = 0; q < TAP_SLOTS - 1; q++)
                window[q] = window[q + 1];
            window[TAP_SLOTS - 1] = it.value;
            if (window_fill < TAP_SLOTS)
                window_fill++;
            // window not yet full: no sum for this sample
            if (window_fill < taps_in_use())
                return;
            want.sum = window_sum(it.prior_sum);
            want.row_done = it.last_in_row;
            expected_sums.push_back(want);
        endfunction

        function void check_sum(logic signed [SUM_W-1:0] got_sum, logic got_done);
            fir_sum_t want;
            if (expected_sums.size() == 0) begin
                $error("unexpected result: sum %0d row_done %0b", got_sum, got_done);
                failures++;
                return;
            end
            want = expected_sums.pop_front();
            if (got_sum !== want.sum) begin
                $error("sum: expected %0d, got %0d", want.sum, got_sum);
                failures++;
            end
            if (got_done !== want.row_done) begin
                $error("row_done: expected %0b, got %0b", want.row_done, got_done);
                failures++;
            end
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction
    endclass

    // Clock, reset and block inputs
    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_command = CMD_LOAD;
    logic [COEF_IDX_W-1:0]         s_coef_index = '0;
    logic signed [VALUE_W-1:0]     s_value = '0;
    logic signed [SUM_W-1:0]       s_prior_sum = '0;
    logic                          s_first_in_row = 1'b0;
    logic                          s_last_in_row = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [SUM_W-1:0]       m_sum;
    logic                          m_row_done;

    correlation_tracker tracker = new();
    bit   coef_written [TAP_SLOTS];
    bit   no_idle = 1'b0;
    int   items_sent = 0;
    int   cycle_count = 0;
    int   hold_left = 0;
    int   phase_taps [8] = '{64, 127, 65, 0, 1, 2, 3, 40};

    row_correlation_fir_unit #(
        .MAX_TAPS(TAP_SLOTS)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_coef_index   (s_coef_index),
        .s_value        (s_value),
        .s_prior_sum    (s_prior_sum),
        .s_first_in_row (s_first_in_row),
        .s_last_in_row  (s_last_in_row),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sum          (m_sum),
        .m_row_done     (m_row_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("row_correlation_fir_unit: mismatch");
            $finish;
        end
    end

    // Result side: check accepted items, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_sum(m_sum, m_row_done);
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!no_idle && $urandom_range(0, 99) < 15) begin
            m_ready <= 1'b0;
            hold_left <= ($urandom_range(0, 9) != 0) ? $urandom_range(0, 2)
                                                      : $urandom_range(3, 60);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int idle_gap();
        int pick;
        if (no_idle)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return -16'sd32768;
        if (pick == 1)
            return 16'sd32767;
        if (pick == 2)
            return '0;
        return VALUE_W'($urandom());
    endfunction

    function automatic logic signed [SUM_W-1:0] rand_prior();
        logic [63:0] raw;
        int          pick;
        pick = $urandom_range(0, 9);
        raw = {$urandom(), $urandom()};
        if (pick == 0)
            return {1'b1, {(SUM_W-1){1'b0}}};
        if (pick == 1)
            return {1'b0, {(SUM_W-1){1'b1}}};
        return raw[SUM_W-1:0];
    endfunction

    function automatic fir_item_t sample_item(logic first, logic last,
                                              logic signed [VALUE_W-1:0] v,
                                              logic signed [SUM_W-1:0] prior);
        fir_item_t it;
        it.command = CMD_SAMPLE;
        it.coef_index = COEF_IDX_W'($urandom_range(0, TAP_SLOTS - 1));
        it.value = v;
        it.prior_sum = prior;
        it.first_in_row = first;
        it.last_in_row = last;
        return it;
    endfunction

    // row markers and prior_sum are don't-care on a load; randomize them anyway
    function automatic fir_item_t load_item(logic [COEF_IDX_W-1:0] idx,
                                            logic signed [VALUE_W-1:0] v);
        fir_item_t it;
        it.command = CMD_LOAD;
        it.coef_index = idx;
        it.value = v;
        it.prior_sum = rand_prior();
        it.first_in_row = 1'($urandom_range(0, 1));
        it.last_in_row = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Present one item and hold it until the block takes it
    task automatic send_item(input fir_item_t it);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= it.command;
        s_coef_index <= it.coef_index;
        s_value <= it.value;
        s_prior_sum <= it.prior_sum;
        s_first_in_row <= it.first_in_row;
        s_last_in_row <= it.last_in_row;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_item(it);
        if (it.command == CMD_LOAD)
            coef_written[it.coef_index] = 1'b1;
        items_sent++;
    endtask

    task automatic send_sample(input logic first, input logic last,
                               input logic signed [VALUE_W-1:0] v,
                               input logic signed [SUM_W-1:0] prior);
        send_item(sample_item(first, last, v, prior));
    endtask

    task automatic send_row(input int len, input logic with_start, input logic with_end);
        for (int k = 0; k < len; k++) begin
            // an occasional coefficient load in the middle of a row
            if ($urandom_range(0, 99) < 4)
                send_item(load_item(COEF_IDX_W'($urandom_range(0, TAP_SLOTS - 1)),
                                    rand_value()));
            send_sample(with_start && k == 0, with_end && k == len - 1,
                        rand_value(), rand_prior());
        end
    endtask

    // Block idle: no sum outstanding and any final pass drained
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.set_register(idx, data);
        @(posedge aclk);
    endtask

    // every tap that the window reads must hold a written coefficient
    task automatic prepare_taps();
        for (int i = 0; i < tracker.taps_in_use(); i++)
            if (!coef_written[i])
                send_item(load_item(COEF_IDX_W'(i), rand_value()));
    endtask

    // Mostly complete rows, plus short rows, rows without a start, stray items
    task automatic run_phase(input int budget);
        int stop_at;
        int taps;
        int pick;
        stop_at = items_sent + budget;
        taps = tracker.taps_in_use();
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_item(load_item(COEF_IDX_W'($urandom_range(0, TAP_SLOTS - 1)),
                                    rand_value()));
            else if (pick < 13)
                send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            rand_value(), rand_prior());
            else if (pick < 20 && taps > 1)
                send_row($urandom_range(1, taps - 1), 1'b1, 1'b1);
            else if (pick < 25)
                send_row($urandom_range(1, 6), 1'b0, 1'($urandom_range(0, 1)));
            else if ($urandom_range(0, 7) == 0)
                send_row(taps + $urandom_range(11, 40), 1'b1, 1'b1);
            else
                send_row(taps + $urandom_range(0, 10), 1'b1, 1'b1);
        end
    endtask

    // Stimulus
    initial begin
        int   taps;
        logic acc_mode;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // one tap, accumulate off: product extremes, row flag, missing row start
        send_item(load_item(0, -16'sd32768));
        send_sample(1'b1, 1'b0, -16'sd32768, rand_prior());
        send_sample(1'b0, 1'b0, 16'sd32767, rand_prior());
        send_item(load_item(0, 16'sd32767));
        send_item(load_item(COEF_IDX_W'(TAP_SLOTS - 1), -16'sd32768));
        send_sample(1'b0, 1'b1, 16'sd32767, rand_prior());
        send_sample(1'b0, 1'b0, '0, rand_prior());

        // two taps, accumulate on: short row, saturation both ways
        wait_idle();
        write_register(CFG_TAP_COUNT, 7'd2);
        write_register(CFG_ACCUMULATE, 7'h7F);
        send_item(load_item(1, 16'sd32767));
        send_sample(1'b1, 1'b1, 16'sd32767, {1'b0, {(SUM_W-1){1'b1}}});
        send_sample(1'b1, 1'b0, 16'sd32767, {1'b0, {(SUM_W-1){1'b1}}});
        send_sample(1'b0, 1'b0, 16'sd32767, {1'b0, {(SUM_W-1){1'b1}}});
        send_sample(1'b0, 1'b1, -16'sd32768, {1'b1, {(SUM_W-1){1'b0}}});
        send_sample(1'b0, 1'b0, 16'sd1, '0);
        send_sample(1'b0, 1'b1, -16'sd1, -40'sd1);

        // tap count zero acts as one tap
        wait_idle();
        write_register(CFG_TAP_COUNT, 7'd0);
        write_register(CFG_ACCUMULATE, 7'h00);
        send_sample(1'b1, 1'b0, 16'sd12345, rand_prior());
        send_sample(1'b0, 1'b1, -16'sd2222, rand_prior());

        // random phases across tap counts and modes
        for (int p = 0; p < 12; p++) begin
            if (p < 8) begin
                taps = phase_taps[p];
                acc_mode = p[0];
            end else begin
                taps = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(1, TAP_SLOTS);
                acc_mode = 1'($urandom_range(0, 1));
            end
            wait_idle();
            write_register(CFG_TAP_COUNT, taps[TAP_COUNT_W-1:0]);
            write_register(CFG_ACCUMULATE, {6'($urandom_range(0, 63)), acc_mode});
            no_idle = (p % 4 == 3);
            prepare_taps();
            run_phase(PHASE_ITEMS);
        end

        wait_idle();
        if (tracker.failures == 0)
            $display("row_correlation_fir_unit: match");
        else
            $display("row_correlation_fir_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
